[rtl/core/lkv_pkg.sv]
package lkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic signed [VAL_W-1:0] DATA_NONE = -32'sd1;

	typedef struct packed {
		logic                    op;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] data;
		logic                    evicted;
	} rsp_t;

endpackage

[rtl/core/lkv_table.sv]
module lkv_table import lkv_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	output rsp_t             rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int AGE_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

	logic [KEY_W-1:0] key_q   [ENTRIES];
	logic [VAL_W-1:0] value_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0] age_q   [ENTRIES];
	logic [CNT_W-1:0] live_q;

	logic             match_hit;
	logic [IDX_W-1:0] match_idx;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] victim_idx;
	logic [CNT_W-1:0] live_m1;
	logic [CMP_W-1:0] eff_cap;
	logic             full;
	logic             promote_en;
	logic             insert_en;
	logic [IDX_W-1:0] promote_idx;
	logic [AGE_W-1:0] promote_age;
	logic [IDX_W-1:0] write_idx;

	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		free_idx = '0;
		victim_idx = '0;
		live_m1 = live_q - CNT_W'(1);
		// scan downward so the lowest numbered entry wins
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == req.key) begin
				match_hit = 1'b1;
				match_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			// live ranks are distinct, so the oldest holds rank live-1
			if (valid_q[i] && age_q[i] == live_m1[AGE_W-1:0]) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		if (capacity == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(capacity);
		end
		full = CMP_W'(live_q) >= eff_cap;
	end

	assign promote_en  = go && (match_hit || (req.op == OP_PUT && full));
	assign insert_en   = go && req.op == OP_PUT && !match_hit && !full;
	assign promote_idx = match_hit ? match_idx : victim_idx;
	assign promote_age = age_q[promote_idx];
	assign write_idx   = match_hit ? match_idx : (full ? victim_idx : free_idx);

	always_comb begin
		rsp.hit = match_hit;
		rsp.data = (req.op == OP_GET && match_hit) ? $signed(value_q[match_idx]) : DATA_NONE;
		rsp.evicted = req.op == OP_PUT && !match_hit && full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (promote_en) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == promote_idx) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && age_q[i] < promote_age) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
			end
			if (insert_en) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == free_idx) begin
						valid_q[i] <= 1'b1;
						age_q[i] <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
				live_q <= live_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && req.op == OP_PUT) begin
			value_q[write_idx] <= req.value;
			if (!match_hit) begin
				key_q[write_idx] <= req.key;
			end
		end
	end

endmodule

[rtl/core/lru_key_value_cache_unit.sv]
// Fully associative key-value cache with least recently used replacement.
// Request channel (req_valid / req_stall / req): one beat is a get or a put
// of a 32-bit key and value. Response channel (rsp_valid / rsp_stall / rsp):
// one beat per request, in order, carrying hit, data and evicted.
// capacity_we / capacity_wdata write the capacity register; write it only
// while no request is in flight.
// A request beat is registered, then looked up and applied to the entry
// table once the response register can take it, and its response is
// registered.
// Throughput: one request per cycle while rsp_stall is low, set by the single pass of parallel key
// compares and rank updates over the ENTRIES register entries.
// Reset empties the table (all entries invalid, ranks zero, no live entries)
// and sets capacity to 16. No clearing sweep is needed.
// While rsp_stall is high a waiting response holds; the request register
// then keeps its beat and req_stall rises, so at most one request waits.
module lru_key_value_cache_unit import lkv_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata
);

	logic             valid_s1;
	req_t             req_s1;
	logic             advance;
	logic [CAP_W-1:0] capacity_q;
	rsp_t             table_rsp;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lkv_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (advance),
		.req     (req_s1),
		.capacity(capacity_q),
		.rsp     (table_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			capacity_q <= CAP_RESET;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= table_rsp;
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench import lkv_pkg::*; ;

	localparam int ENTRIES = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int POOL_N = 20;

	class lru_scoreboard;
		logic [KEY_W-1:0] keys [ENTRIES];
		logic [VAL_W-1:0] vals [ENTRIES];
		bit               valid [ENTRIES];
		int unsigned      rank [ENTRIES];
		int unsigned      live;
		int unsigned      cap_eff;
		rsp_t             rsp_q [$];
		int               errors;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				valid[i] = 1'b0;
				rank[i] = 0;
			end
			live = 0;
			cap_eff = CAP_RESET;
			errors = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			if (c == 0)
				cap_eff = 1;
			else if (c > ENTRIES)
				cap_eff = ENTRIES;
			else
				cap_eff = c;
		endfunction

		// entry s becomes rank 0; everything younger than it ages by one
		function void make_newest(int s);
			int unsigned old;
			old = rank[s];
			for (int i = 0; i < ENTRIES; i++)
				if (valid[i] && i != s && rank[i] < old)
					rank[i] = rank[i] + 1;
			rank[s] = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int          match;
			int          slot;
			int unsigned oldest;
			bit          evict;
			match = -1;
			slot = -1;
			evict = 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (match < 0 && valid[i] && keys[i] == r.key)
					match = i;
			end
			e.hit = (match >= 0);
			e.data = DATA_NONE;
			e.evicted = 1'b0;
			if (r.op == OP_GET) begin
				if (match >= 0) begin
					e.data = vals[match];
					make_newest(match);
				end
			end else if (match >= 0) begin
				vals[match] = r.value;
				make_newest(match);
			end else begin
				if (live < cap_eff) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !valid[i])
							slot = i;
				end
				if (slot < 0) begin
					oldest = 0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid[i] && (slot < 0 || rank[i] > oldest)) begin
							slot = i;
							oldest = rank[i];
						end
					end
					evict = (slot >= 0);
					if (slot < 0)
						slot = 0;
				end
				if (evict) begin
					// victim holds the top rank, so this ages every other entry
					make_newest(slot);
				end else begin
					for (int i = 0; i < ENTRIES; i++)
						if (valid[i])
							rank[i] = rank[i] + 1;
					valid[slot] = 1'b1;
					rank[slot] = 0;
					live = live + 1;
				end
				keys[slot] = r.key;
				vals[slot] = r.value;
				e.evicted = evict;
			end
			rsp_q.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (rsp_q.size() == 0) begin
				$display("%0t: response beat with none expected: hit %0b data %h evicted %0b",
					$time, a.hit, a.data, a.evicted);
				errors++;
				return;
			end
			e = rsp_q.pop_front();
			if (a.hit !== e.hit) begin
				$display("%0t: hit expected %0b actual %0b", $time, e.hit, a.hit);
				errors++;
			end
			if (a.data !== e.data) begin
				$display("%0t: data expected %h actual %h", $time, e.data, a.data);
				errors++;
			end
			if (a.evicted !== e.evicted) begin
				$display("%0t: evicted expected %0b actual %0b", $time, e.evicted, a.evicted);
				errors++;
			end
		endfunction

		function int pending();
			return rsp_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             capacity_we = 1'b0;
	logic [CAP_W-1:0] capacity_wdata = '0;

	lru_scoreboard    sb;
	bit               quiet = 1'b0;
	int               cycles = 0;
	int               stall_left = 0;
	logic [KEY_W-1:0] key_pool [POOL_N];

	lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// response side: check every accepted beat, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid === 1'b1 && !rsp_stall)
				sb.check_response(rsp);
			if (!quiet && stall_left != 0) begin
				stall_left = stall_left - 1;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// valid stays high across back-to-back beats; it only drops for a gap
	task automatic send_req(input req_t r);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic put_item(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		req_t r;
		r.op = OP_PUT;
		r.key = k;
		r.value = v;
		send_req(r);
	endtask

	task automatic get_item(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		req_t r;
		r.op = OP_GET;
		r.key = k;
		r.value = v;
		send_req(r);
	endtask

	// drain all responses before touching the register
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= c;
		@(posedge clk);
		capacity_we <= 1'b0;
		sb.set_capacity(c);
	endtask

	task automatic run_random(input int n);
		req_t r;
		int   sel;
		for (int i = 0; i < n; i++) begin
			r.op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
			sel = $urandom_range(0, 19);
			if (sel < 3)
				r.key = $urandom;
			else if (sel < 8)
				r.key = key_pool[$urandom_range(0, 3)];
			else
				r.key = key_pool[$urandom_range(0, POOL_N - 1)];
			sel = $urandom_range(0, 15);
			if (sel == 0)
				r.value = DATA_NONE;
			else if (sel == 1)
				r.value = '0;
			else
				r.value = $urandom;
			send_req(r);
		end
		// replace up to three keys outside the four hot ones so later phases see fresh misses
		for (int i = 0; i < 3; i++)
			key_pool[$urandom_range(4, POOL_N - 1)] = $urandom;
	endtask

	initial begin
		sb = new();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hffff_ffff;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7fff_ffff;
		for (int i = 4; i < POOL_N; i++)
			key_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extreme keys and values, update on put hit
		get_item(32'h0000_0000, 32'h0000_0000);
		put_item(32'h8000_0000, 32'h7fff_ffff);
		put_item(32'h7fff_ffff, 32'h8000_0000);
		put_item(32'hffff_ffff, 32'hffff_ffff);
		put_item(32'h0000_0000, 32'h0000_0000);
		get_item(32'h8000_0000, 32'h0000_0000);
		get_item(32'hffff_ffff, 32'h5555_5555);
		put_item(32'h7fff_ffff, 32'h1234_5678);
		get_item(32'h7fff_ffff, 32'hffff_ffff);
		get_item(32'h5555_5555, 32'haaaa_aaaa);

		// capacity below the live count: each put miss replaces one entry
		write_capacity(5'd2);
		put_item(32'h0f0f_0f0f, 32'hf0f0_f0f0);
		put_item(32'hf0f0_f0f0, 32'h0f0f_0f0f);
		get_item(32'h0000_0000, 32'h0000_0000);
		get_item(32'h0f0f_0f0f, 32'h0000_0000);

		write_capacity(5'd1);
		put_item(32'haaaa_aaaa, 32'h5555_5555);
		get_item(32'haaaa_aaaa, 32'h0000_0000);

		// zero behaves as one
		write_capacity(5'd0);
		put_item(32'h5555_5555, 32'haaaa_aaaa);
		put_item(32'h8000_0000, 32'h0000_0001);
		get_item(32'h5555_5555, 32'h0000_0000);

		write_capacity(5'd8);
		run_random(200);
		write_capacity(5'd5);
		run_random(200);
		write_capacity(5'd12);
		run_random(200);
		// above the table size saturates
		write_capacity(5'd31);
		run_random(250);
		write_capacity(5'd17);
		run_random(200);
		write_capacity(5'd16);
		run_random(200);
		write_capacity(5'd1);
		run_random(150);
		write_capacity(5'd3);
		run_random(200);
		write_capacity(5'd16);
		quiet = 1'b1;
		run_random(300);

		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
